>>> rtl/core/jdg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jdg_pkg;

  // Field widths
  localparam int unsigned JD_DAYS_W   = 26;
  localparam int unsigned YEAR_W      = 18;
  localparam int unsigned MONTH_W     = 4;
  localparam int unsigned DAY_W       = 5;
  localparam int unsigned HOURS_W     = 5;
  localparam int unsigned MINUTES_W   = 6;
  localparam int unsigned SECONDS_W   = 6;
  localparam int unsigned SUBSEC_W    = 16;

  // Parameter defaults
  localparam int unsigned DEF_FRAC_BITS   = 32;
  localparam int unsigned DEF_QUEUE_DEPTH = 4;

  // Civil day count and the shifted 400-year numerator 4*j-1
  localparam int unsigned DAYS_ADJ_W = JD_DAYS_W + 1;
  localparam int unsigned N_W        = JD_DAYS_W + 2;

  localparam logic [20:0] EPOCH_OFFSET = 21'd1721119;

  // 400-year cycle: divide by reciprocal, then one correction step
  localparam logic [17:0] Q400_DAYS    = 18'd146097;
  localparam logic [12:0] Q400_RECIP   = 13'd7349;   // floor(2^30 / 146097)
  localparam int unsigned Q400_SHIFT   = 30;
  localparam int unsigned Q400_RECIP_W = 13;
  localparam int unsigned CENT_W       = 11;         // quotient of the 400-year step
  localparam int unsigned R400_W       = 19;         // remainder before correction
  localparam int unsigned J400_W       = 18;

  // 4-year cycle
  localparam logic [10:0] Q4_DAYS   = 11'd1461;
  localparam logic [9:0]  Q4_RECIP  = 10'd717;       // floor(2^20 / 1461)
  localparam int unsigned Q4_SHIFT  = 20;
  localparam int unsigned YR2_W     = 7;             // year within the century
  localparam int unsigned R4_W      = 12;

  // 153-day (five month) cycle
  localparam logic [7:0]  M5_DAYS   = 8'd153;
  localparam logic [4:0]  M5_RECIP  = 5'd26;         // floor(2^12 / 153)
  localparam int unsigned M5_SHIFT  = 12;
  localparam int unsigned N3_W      = 11;

  // Divide by five for the day of month, exact below 160
  localparam logic [7:0]  DIV5_RECIP = 8'd205;
  localparam int unsigned DIV5_SHIFT = 10;

  localparam logic [6:0]  YEARS_PER_CENT = 7'd100;
  localparam logic [4:0]  HOURS_PER_DAY  = 5'd24;
  localparam logic [5:0]  MIN_PER_HOUR   = 6'd60;
  localparam logic [5:0]  SEC_PER_MIN    = 6'd60;

  // Month index from March: below this stays in the same year, from it wraps into the next
  localparam logic [MONTH_W-1:0] MONTH_WRAP = 4'd10;

  typedef struct packed {
    logic [HOURS_W-1:0]   hours;
    logic [MINUTES_W-1:0] minutes;
    logic [SECONDS_W-1:0] seconds;
    logic [SUBSEC_W-1:0]  subsec;
  } tod_t;

endpackage

`default_nettype wire

>>> rtl/core/jdg_front.sv
`timescale 1ns / 1ps
`default_nettype none

module jdg_front #(
  parameter int unsigned FRAC_BITS = jdg_pkg::DEF_FRAC_BITS,
  parameter int unsigned ITEM_W    = 1 + jdg_pkg::N_W + FRAC_BITS
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [jdg_pkg::JD_DAYS_W-1:0]  jd_days_i,
  input  wire logic [FRAC_BITS-1:0]           jd_frac_i,
  output logic                                push_valid_o,
  input  wire logic                           push_stall_i,
  output logic [ITEM_W-1:0]                   push_data_o
);
  import jdg_pkg::*;

  logic                  half_ge;
  logic [FRAC_BITS-1:0]  frac_civil;
  logic [DAYS_ADJ_W-1:0] days_adj;
  logic [DAYS_ADJ_W-1:0] day_cnt;
  logic                  early;
  logic [N_W-1:0]        numer;
  logic                  load;
  logic                  valid_q, valid_d;
  logic [ITEM_W-1:0]     item_q, item_d;

  // Julian days start at noon: move half a day into the civil day
  assign half_ge    = jd_frac_i[FRAC_BITS-1];
  assign frac_civil = {~jd_frac_i[FRAC_BITS-1], jd_frac_i[FRAC_BITS-2:0]};
  assign days_adj   = DAYS_ADJ_W'(jd_days_i) + DAYS_ADJ_W'(half_ge);
  assign early      = days_adj <= DAYS_ADJ_W'(EPOCH_OFFSET);
  assign day_cnt    = days_adj - DAYS_ADJ_W'(EPOCH_OFFSET);
  assign numer      = {day_cnt[JD_DAYS_W-1:0], 2'b00} - N_W'(1);

  assign in_stall_o   = valid_q && push_stall_i;
  assign load         = in_valid_i && !in_stall_o;
  assign push_valid_o = valid_q;
  assign push_data_o  = item_q;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (load) begin
      valid_d = 1'b1;
      item_d  = {early, numer, frac_civil};
    end else if (!push_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule

`default_nettype wire

>>> rtl/core/jdg_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module jdg_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = jdg_pkg::DEF_QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_stall_o,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_stall_i,
  output logic [WIDTH-1:0]      pop_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push;
  logic             pop;

  assign push_stall_o = cnt_q == CNT_W'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && !push_stall_o;
  assign pop          = pop_valid_o && !pop_stall_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_cnt_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == CNT_W'($past(cnt_q) + 1'b1))
    else $error("queue count missed a push");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with pointers apart");

endmodule

`default_nettype wire

>>> rtl/core/jdg_back.sv
`timescale 1ns / 1ps
`default_nettype none

module jdg_back #(
  parameter int unsigned FRAC_BITS = jdg_pkg::DEF_FRAC_BITS,
  parameter int unsigned ITEM_W    = 1 + jdg_pkg::N_W + FRAC_BITS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [ITEM_W-1:0]             in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [jdg_pkg::YEAR_W-1:0]         year_o,
  output logic [jdg_pkg::MONTH_W-1:0]        month_o,
  output logic [jdg_pkg::DAY_W-1:0]          day_o,
  output logic [jdg_pkg::HOURS_W-1:0]        hours_o,
  output logic [jdg_pkg::MINUTES_W-1:0]      minutes_o,
  output logic [jdg_pkg::SECONDS_W-1:0]      seconds_whole_o,
  output logic [jdg_pkg::SUBSEC_W-1:0]       seconds_frac_o,
  output logic                               range_error_o
);
  import jdg_pkg::*;

  localparam int unsigned NSTG  = 10;
  localparam int unsigned P1_W  = N_W + Q400_RECIP_W;
  localparam int unsigned P2_W  = N_W + 1;
  localparam int unsigned HP_W  = FRAC_BITS + HOURS_W;
  localparam int unsigned MP_W  = FRAC_BITS + MINUTES_W;
  localparam int unsigned SFW_W = FRAC_BITS + SUBSEC_W;

  logic                 en;
  logic [NSTG-1:0]      vld_q, vld_d;
  logic [NSTG-2:0]      err_q;

  logic                 in_err;
  logic [N_W-1:0]       in_n;
  logic [FRAC_BITS-1:0] in_frac;

  // Date lane
  logic [P1_W-1:0]      p1;
  logic [N_W-1:0]       s1_n_q;
  logic [CENT_W-1:0]    s1_q_q;
  logic [P2_W-1:0]      p2, diff2;
  logic [R400_W-1:0]    s2_r_q;
  logic [CENT_W-1:0]    s2_q_q;
  logic                 ge3;
  logic [J400_W-1:0]    j3;
  logic [CENT_W-1:0]    y3;
  logic [J400_W-1:0]    s3_n2_q;
  logic [CENT_W-1:0]    s3_y_q;
  logic [27:0]          p4;
  logic [YEAR_W-1:0]    y100_4;
  logic [YR2_W-1:0]     s4_q_q;
  logic [J400_W-1:0]    s4_n2_q;
  logic [YEAR_W-1:0]    s4_y100_q;
  logic [J400_W-1:0]    p5;
  logic [R4_W-1:0]      s5_r_q;
  logic [YR2_W-1:0]     s5_q_q;
  logic [YEAR_W-1:0]    s5_y100_q;
  logic                 ge6;
  logic [R4_W-2:0]      r6;
  logic [YR2_W-1:0]     c6;
  logic [R4_W-1:0]      rsum6;
  logic [8:0]           dd6;
  logic [N3_W-1:0]      n3_6;
  logic [N3_W-1:0]      s6_n3_q;
  logic [YR2_W-1:0]     s6_c_q;
  logic [YEAR_W-1:0]    s6_y100_q;
  logic [15:0]          p7;
  logic [N3_W-1:0]      s7_n3_q;
  logic [MONTH_W-1:0]   s7_m_q;
  logic [YR2_W-1:0]     s7_c_q;
  logic [YEAR_W-1:0]    s7_y100_q;
  logic [N3_W-1:0]      p8;
  logic [8:0]           s8_r_q;
  logic [MONTH_W-1:0]   s8_m_q;
  logic [YR2_W-1:0]     s8_c_q;
  logic [YEAR_W-1:0]    s8_y100_q;
  logic                 ge9;
  logic [7:0]           r9;
  logic [MONTH_W-1:0]   m9;
  logic [7:0]           s9_x_q;
  logic [MONTH_W-1:0]   s9_m_q;
  logic [YR2_W-1:0]     s9_c_q;
  logic [YEAR_W-1:0]    s9_y100_q;
  logic [14:0]          p10;
  logic                 wrap10;
  logic [YEAR_W-1:0]    year_d;
  logic [MONTH_W-1:0]   month_d;

  // Time lane
  logic [HP_W-1:0]      hp;
  logic [MP_W-1:0]      mp, sp;
  logic [SFW_W-1:0]     sfw;
  logic [HOURS_W-1:0]   s1_hr_q, s2_hr_q, s3_hr_q;
  logic [MINUTES_W-1:0] s2_mn_q, s3_mn_q;
  logic [SECONDS_W-1:0] s3_sc_q;
  logic [FRAC_BITS-1:0] s1_g_q, s2_g_q, s3_g_q;
  tod_t                 tod_q [4:9];

  logic [YEAR_W-1:0]    year_q;
  logic [MONTH_W-1:0]   month_q;
  logic [DAY_W-1:0]     day_q;
  tod_t                 tod_out_q;
  logic                 err_out_q;

  assign {in_err, in_n, in_frac} = in_data_i;

  // Advance every stage unless the output register is held
  assign en         = !(vld_q[NSTG-1] && out_stall_i);
  assign in_stall_o = !en;
  assign vld_d      = {vld_q[NSTG-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  // Stage 1: estimate of the 400-year quotient; hour from day fraction
  assign p1 = P1_W'(in_n) * P1_W'(Q400_RECIP);
  assign hp = HP_W'(in_frac) * HP_W'(HOURS_PER_DAY);

  // Stage 2: remainder of the estimate; minute
  assign p2    = P2_W'(s1_q_q) * P2_W'(Q400_DAYS);
  assign diff2 = P2_W'(s1_n_q) - p2;
  assign mp    = MP_W'(s1_g_q) * MP_W'(MIN_PER_HOUR);

  // Stage 3: correct the quotient by one; second
  assign ge3 = s2_r_q >= R400_W'(Q400_DAYS);
  assign j3  = ge3 ? J400_W'(s2_r_q - R400_W'(Q400_DAYS)) : s2_r_q[J400_W-1:0];
  assign y3  = ge3 ? CENT_W'(s2_q_q + 1'b1) : s2_q_q;
  assign sp  = MP_W'(s2_g_q) * MP_W'(SEC_PER_MIN);

  // Stage 4: estimate of the 4-year quotient; sub-second
  assign p4     = 28'(s3_n2_q) * 28'(Q4_RECIP);
  assign y100_4 = YEAR_W'(s3_y_q) * YEAR_W'(YEARS_PER_CENT);
  assign sfw    = {s3_g_q, {SUBSEC_W{1'b0}}} >> FRAC_BITS;

  // Stage 5: remainder of the estimate
  assign p5 = J400_W'(s4_q_q) * J400_W'(Q4_DAYS);

  // Stage 6: correct, then day of year and 5*d-3 for the month step
  assign ge6   = s5_r_q >= R4_W'(Q4_DAYS);
  assign r6    = ge6 ? (R4_W-1)'(s5_r_q - R4_W'(Q4_DAYS)) : s5_r_q[R4_W-2:0];
  assign c6    = ge6 ? YR2_W'(s5_q_q + 1'b1) : s5_q_q;
  assign rsum6 = R4_W'(r6) + R4_W'(4);
  assign dd6   = rsum6[10:2];
  assign n3_6  = N3_W'({dd6, 2'b00}) + N3_W'(dd6) - N3_W'(3);

  // Stage 7: estimate of the month index
  assign p7 = 16'(s6_n3_q) * 16'(M5_RECIP);

  // Stage 8: remainder of the estimate
  assign p8 = N3_W'(s7_m_q) * N3_W'(M5_DAYS);

  // Stage 9: correct the month index
  assign ge9 = s8_r_q >= 9'(M5_DAYS);
  assign r9  = ge9 ? 8'(s8_r_q - 9'(M5_DAYS)) : s8_r_q[7:0];
  assign m9  = ge9 ? MONTH_W'(s8_m_q + 1'b1) : s8_m_q;

  // Stage 10: day of month, month from March to January base, year
  assign p10     = 15'(s9_x_q) * 15'(DIV5_RECIP);
  assign wrap10  = s9_m_q >= MONTH_WRAP;
  assign year_d  = s9_y100_q + YEAR_W'(s9_c_q) + YEAR_W'(wrap10);
  assign month_d = wrap10 ? MONTH_W'(s9_m_q - MONTH_W'(9)) : MONTH_W'(s9_m_q + MONTH_W'(3));

  always_ff @(posedge clk_i) begin
    if (en) begin
      err_q <= {err_q[NSTG-3:0], in_err};

      s1_n_q    <= in_n;
      s1_q_q    <= p1[Q400_SHIFT +: CENT_W];
      s1_hr_q   <= hp[FRAC_BITS +: HOURS_W];
      s1_g_q    <= hp[FRAC_BITS-1:0];

      s2_r_q    <= diff2[R400_W-1:0];
      s2_q_q    <= s1_q_q;
      s2_hr_q   <= s1_hr_q;
      s2_mn_q   <= mp[FRAC_BITS +: MINUTES_W];
      s2_g_q    <= mp[FRAC_BITS-1:0];

      s3_n2_q   <= {j3[J400_W-1:2], 2'b11};
      s3_y_q    <= y3;
      s3_hr_q   <= s2_hr_q;
      s3_mn_q   <= s2_mn_q;
      s3_sc_q   <= sp[FRAC_BITS +: SECONDS_W];
      s3_g_q    <= sp[FRAC_BITS-1:0];

      s4_q_q    <= p4[Q4_SHIFT +: YR2_W];
      s4_n2_q   <= s3_n2_q;
      s4_y100_q <= y100_4;
      tod_q[4]  <= '{hours: s3_hr_q, minutes: s3_mn_q, seconds: s3_sc_q,
                     subsec: sfw[SUBSEC_W-1:0]};

      s5_r_q    <= R4_W'(s4_n2_q - p5);
      s5_q_q    <= s4_q_q;
      s5_y100_q <= s4_y100_q;

      s6_n3_q   <= n3_6;
      s6_c_q    <= c6;
      s6_y100_q <= s5_y100_q;

      s7_n3_q   <= s6_n3_q;
      s7_m_q    <= p7[M5_SHIFT +: MONTH_W];
      s7_c_q    <= s6_c_q;
      s7_y100_q <= s6_y100_q;

      s8_r_q    <= 9'(s7_n3_q - p8);
      s8_m_q    <= s7_m_q;
      s8_c_q    <= s7_c_q;
      s8_y100_q <= s7_y100_q;

      s9_x_q    <= r9 + 8'd5;
      s9_m_q    <= m9;
      s9_c_q    <= s8_c_q;
      s9_y100_q <= s8_y100_q;

      for (int k = 5; k <= 9; k++) begin
        tod_q[k] <= tod_q[k-1];
      end

      // Drop every field of a day before the epoch
      err_out_q <= err_q[NSTG-2];
      if (err_q[NSTG-2]) begin
        year_q    <= '0;
        month_q   <= '0;
        day_q     <= '0;
        tod_out_q <= '0;
      end else begin
        year_q    <= year_d;
        month_q   <= month_d;
        day_q     <= p10[DIV5_SHIFT +: DAY_W];
        tod_out_q <= tod_q[9];
      end
    end
  end

  assign out_valid_o     = vld_q[NSTG-1];
  assign year_o          = year_q;
  assign month_o         = month_q;
  assign day_o           = day_q;
  assign hours_o         = tod_out_q.hours;
  assign minutes_o       = tod_out_q.minutes;
  assign seconds_whole_o = tod_out_q.seconds;
  assign seconds_frac_o  = tod_out_q.subsec;
  assign range_error_o   = err_out_q;

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && range_error_o) |->
      (year_o == '0 && month_o == '0 && day_o == '0 && hours_o == '0 &&
       minutes_o == '0 && seconds_whole_o == '0 && seconds_frac_o == '0))
    else $error("range error with nonzero fields");

  a_date_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !range_error_o) |->
      (month_o >= MONTH_W'(1) && month_o <= MONTH_W'(12) && day_o != '0 &&
       hours_o <= HOURS_W'(23) && minutes_o <= MINUTES_W'(59) &&
       seconds_whole_o <= SECONDS_W'(59)))
    else $error("calendar field out of range");

endmodule

`default_nettype wire

>>> rtl/core/julian_day_to_gregorian_datetime_top.sv
// Julian date to Gregorian date and time of day.
//
// Input channel: in_valid_i / in_stall_o with jd_days_i and jd_frac_i (day
// fraction in units of 2^-FRAC_BITS day). Output channel: out_valid_o /
// out_stall_i with year, month, day, hours, minutes, whole seconds, seconds
// in 2^-16 units and range_error_o. A request moves on a rising edge with
// valid high and stall low. Every request gives exactly one result, in order.
//
// Throughput: one request per cycle sustained while the output is not held.
// From acceptance, a request passes through the front register, then the
// queue and then the ten-stage back pipeline, whose last stage is the output
// register.
//
// A held output freezes the back pipeline; the queue (QUEUE_DEPTH entries)
// and the front register keep taking requests until they are full, and only
// then does in_stall_o rise. Reset empties the front register, the queue and
// the pipeline; there is no other state.
`timescale 1ns / 1ps
`default_nettype none

module julian_day_to_gregorian_datetime_top #(
  parameter int unsigned FRAC_BITS   = jdg_pkg::DEF_FRAC_BITS,
  parameter int unsigned QUEUE_DEPTH = jdg_pkg::DEF_QUEUE_DEPTH
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [jdg_pkg::JD_DAYS_W-1:0] jd_days_i,
  input  wire logic [FRAC_BITS-1:0]          jd_frac_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [jdg_pkg::YEAR_W-1:0]         year_o,
  output logic [jdg_pkg::MONTH_W-1:0]        month_o,
  output logic [jdg_pkg::DAY_W-1:0]          day_o,
  output logic [jdg_pkg::HOURS_W-1:0]        hours_o,
  output logic [jdg_pkg::MINUTES_W-1:0]      minutes_o,
  output logic [jdg_pkg::SECONDS_W-1:0]      seconds_whole_o,
  output logic [jdg_pkg::SUBSEC_W-1:0]       seconds_frac_o,
  output logic                               range_error_o
);
  import jdg_pkg::*;

  localparam int unsigned ITEM_W = 1 + N_W + FRAC_BITS;

  logic              fr_valid;
  logic              fr_stall;
  logic [ITEM_W-1:0] fr_data;
  logic              bk_valid;
  logic              bk_stall;
  logic [ITEM_W-1:0] bk_data;

  jdg_front #(
    .FRAC_BITS (FRAC_BITS),
    .ITEM_W    (ITEM_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .jd_days_i    (jd_days_i),
    .jd_frac_i    (jd_frac_i),
    .push_valid_o (fr_valid),
    .push_stall_i (fr_stall),
    .push_data_o  (fr_data)
  );

  jdg_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_stall_o (fr_stall),
    .push_data_i  (fr_data),
    .pop_valid_o  (bk_valid),
    .pop_stall_i  (bk_stall),
    .pop_data_o   (bk_data)
  );

  jdg_back #(
    .FRAC_BITS (FRAC_BITS),
    .ITEM_W    (ITEM_W)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (bk_valid),
    .in_stall_o      (bk_stall),
    .in_data_i       (bk_data),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .year_o          (year_o),
    .month_o         (month_o),
    .day_o           (day_o),
    .hours_o         (hours_o),
    .minutes_o       (minutes_o),
    .seconds_whole_o (seconds_whole_o),
    .seconds_frac_o  (seconds_frac_o),
    .range_error_o   (range_error_o)
  );

endmodule

`default_nettype wire

>>> test/tb_julian_day_to_gregorian_datetime_top.sv
`timescale 1ns / 1ps

module tb_julian_day_to_gregorian_datetime_top;
  import jdg_pkg::*;

  localparam int unsigned FRAC_W     = DEF_FRAC_BITS;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned DRAIN_CYC  = 30;

  localparam longint unsigned EPOCH_DAYS   = 64'd1721119;
  localparam longint unsigned CYC400_DAYS  = 64'd146097;
  localparam longint unsigned CYC4_DAYS    = 64'd1461;
  localparam longint unsigned CYC5M_DAYS   = 64'd153;
  localparam longint unsigned UNITS_DAY    = 64'd5662310400;
  localparam longint unsigned UNITS_HOUR   = 64'd235929600;
  localparam longint unsigned UNITS_MINUTE = 64'd3932160;
  localparam longint unsigned FIRST_DAY    = 64'd2200000;
  localparam longint unsigned LAST_DAY     = 64'd2600000;

  typedef enum int {RX_RANDOM, RX_FREE, RX_HEAVY} rx_mode_e;

  typedef struct packed {
    logic [YEAR_W-1:0]    year;
    logic [MONTH_W-1:0]   month;
    logic [DAY_W-1:0]     day;
    logic [HOURS_W-1:0]   hours;
    logic [MINUTES_W-1:0] minutes;
    logic [SECONDS_W-1:0] seconds;
    logic [SUBSEC_W-1:0]  subsec;
    logic                 range_error;
  } datetime_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [JD_DAYS_W-1:0] jd_days_i;
  logic [FRAC_W-1:0]    jd_frac_i;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [YEAR_W-1:0]    year_o;
  logic [MONTH_W-1:0]   month_o;
  logic [DAY_W-1:0]     day_o;
  logic [HOURS_W-1:0]   hours_o;
  logic [MINUTES_W-1:0] minutes_o;
  logic [SECONDS_W-1:0] seconds_whole_o;
  logic [SUBSEC_W-1:0]  seconds_frac_o;
  logic                 range_error_o;

  datetime_t   pending_dates[$];
  int unsigned error_cnt = 0;
  int unsigned idle_cnt = 0;
  int unsigned stall_hold = 0;
  bit          no_gaps = 1'b0;
  rx_mode_e    rx_mode = RX_RANDOM;

  julian_day_to_gregorian_datetime_top #(
    .FRAC_BITS(FRAC_W)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .jd_days_i      (jd_days_i),
    .jd_frac_i      (jd_frac_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .year_o         (year_o),
    .month_o        (month_o),
    .day_o          (day_o),
    .hours_o        (hours_o),
    .minutes_o      (minutes_o),
    .seconds_whole_o(seconds_whole_o),
    .seconds_frac_o (seconds_frac_o),
    .range_error_o  (range_error_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic datetime_t civil_datetime(logic [JD_DAYS_W-1:0] jd_days,
                                               logic [FRAC_W-1:0] jd_frac);
    longint unsigned days, f, half, j, y, d, c, m, t, rem;
    datetime_t r;
    days = 64'(jd_days);
    f    = 64'(jd_frac);
    half = 64'd1 << (FRAC_W - 1);
    r    = '0;
    // Julian days start at noon: shift to the civil day
    if (f >= half) begin
      f    = f - half;
      days = days + 1;
    end else begin
      f = f + half;
    end
    if (days < EPOCH_DAYS + 1) begin
      r.range_error = 1'b1;
      return r;
    end
    j = days - EPOCH_DAYS;
    y = (4 * j - 1) / CYC400_DAYS;
    j = 4 * j - 1 - CYC400_DAYS * y;
    d = j / 4;
    c = (4 * d + 3) / CYC4_DAYS;
    d = 4 * d + 3 - CYC4_DAYS * c;
    d = (d + 4) / 4;
    m = (5 * d - 3) / CYC5M_DAYS;
    d = 5 * d - 3 - CYC5M_DAYS * m;
    d = (d + 5) / 5;
    y = 100 * y + c;
    if (m < 10) begin
      m = m + 3;
    end else begin
      m = m - 9;
      y = y + 1;
    end
    // Split the product so it stays within 64 bits
    if (FRAC_W < 24) begin
      t = (f * UNITS_DAY) >> FRAC_W;
    end else begin
      t = ((f >> 24) * UNITS_DAY + (((f & 64'hFFFFFF) * UNITS_DAY) >> 24)) >> (FRAC_W - 24);
    end
    r.year    = y[YEAR_W-1:0];
    r.month   = m[MONTH_W-1:0];
    r.day     = d[DAY_W-1:0];
    r.hours   = HOURS_W'(t / UNITS_HOUR);
    rem       = t % UNITS_HOUR;
    r.minutes = MINUTES_W'(rem / UNITS_MINUTE);
    rem       = rem % UNITS_MINUTE;
    r.seconds = SECONDS_W'(rem >> 16);
    r.subsec  = rem[15:0];
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned pick;
    if (no_gaps) return 0;
    pick = $urandom_range(99, 0);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  task automatic send_request(logic [JD_DAYS_W-1:0] jd_days, logic [FRAC_W-1:0] jd_frac);
    int unsigned gap;
    in_valid_i <= 1'b1;
    jd_days_i  <= jd_days;
    jd_frac_i  <= jd_frac;
    do @(posedge clk_i); while (in_stall_o);
    pending_dates.push_back(civil_datetime(jd_days, jd_frac));
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic [FRAC_W-1:0] random_frac();
    logic [FRAC_W-1:0] f;
    case ($urandom_range(7, 0))
      0: f = '0;
      1: f = '1;
      2: f = {1'b0, {(FRAC_W-1){1'b1}}};
      3: f = {1'b1, {(FRAC_W-1){1'b0}}};
      default: f = FRAC_W'({$urandom, $urandom});
    endcase
    return f;
  endfunction

  function automatic logic [JD_DAYS_W-1:0] random_days();
    int unsigned pick;
    pick = $urandom_range(99, 0);
    // Half the dates are ordinary; the rest sit on the epoch edge or span the field
    if (pick < 50) return JD_DAYS_W'($urandom_range(32'(LAST_DAY), 32'(FIRST_DAY)));
    if (pick < 75) return JD_DAYS_W'($urandom_range((1 << JD_DAYS_W) - 1, 32'(EPOCH_DAYS)));
    if (pick < 90) begin
      return JD_DAYS_W'($urandom_range(32'(EPOCH_DAYS + 10), 32'(EPOCH_DAYS - 10)));
    end
    return JD_DAYS_W'($urandom);
  endfunction

  task automatic test_directed_dates();
    send_request('0, '0);
    send_request('0, '1);
    // Epoch edge: the half-day carry decides the range error
    send_request(JD_DAYS_W'(EPOCH_DAYS - 1), '1);
    send_request(JD_DAYS_W'(EPOCH_DAYS), '0);
    send_request(JD_DAYS_W'(EPOCH_DAYS), {1'b0, {(FRAC_W-1){1'b1}}});
    send_request(JD_DAYS_W'(EPOCH_DAYS), {1'b1, {(FRAC_W-1){1'b0}}});
    send_request(JD_DAYS_W'(EPOCH_DAYS + 1), '0);
    send_request(26'd2451545, '0);
    send_request(26'd2451544, {1'b1, {(FRAC_W-1){1'b0}}});
    send_request(26'd2451545, 32'h0000_0001);
    send_request(26'd2451545, 32'h4000_0000);
    // Leap day, century non-leap year and year end
    send_request(26'd2451603, '0);
    send_request(26'd2451604, '1);
    send_request(26'd2488127, {1'b1, {(FRAC_W-1){1'b0}}});
    send_request(26'd2488128, '0);
    send_request(26'd2459580, 32'hC000_0000);
    send_request(26'd2459945, {1'b0, {(FRAC_W-1){1'b1}}});
    send_request('1, '1);
    send_request('1, '0);
    send_request(26'h2000000, 32'h5555_5555);
    send_request(26'h1555555, 32'hAAAA_AAAA);
  endtask

  task automatic test_random_dates(int unsigned n);
    repeat (n) send_request(random_days(), random_frac());
  endtask

  task automatic test_streaming(int unsigned n);
    no_gaps = 1'b1;
    rx_mode = RX_FREE;
    repeat (n) send_request(random_days(), random_frac());
    no_gaps = 1'b0;
    rx_mode = RX_RANDOM;
  endtask

  task automatic test_backpressure(int unsigned n);
    no_gaps = 1'b1;
    rx_mode = RX_HEAVY;
    repeat (n) send_request(random_days(), random_frac());
    no_gaps = 1'b0;
    rx_mode = RX_RANDOM;
  endtask

  always @(posedge clk_i) begin
    int unsigned pick;
    if (rx_mode == RX_FREE) begin
      stall_hold = 0;
      out_stall_i <= 1'b0;
    end else if (stall_hold != 0) begin
      stall_hold--;
      out_stall_i <= 1'b1;
    end else begin
      pick = $urandom_range(99, 0);
      if (pick < 65) begin
        out_stall_i <= 1'b0;
      end else if (pick < ((rx_mode == RX_HEAVY) ? 80 : 96)) begin
        out_stall_i <= 1'b1;
        stall_hold = $urandom_range(2, 0);
      end else begin
        out_stall_i <= 1'b1;
        stall_hold = $urandom_range(40, 10);
      end
    end
  end

  task automatic report_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      error_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    datetime_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_dates.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual year %0d month %0d day %0d",
                 $time, year_o, month_o, day_o);
        error_cnt++;
      end else begin
        want = pending_dates.pop_front();
        report_field("year", 64'(want.year), 64'(year_o));
        report_field("month", 64'(want.month), 64'(month_o));
        report_field("day", 64'(want.day), 64'(day_o));
        report_field("hours", 64'(want.hours), 64'(hours_o));
        report_field("minutes", 64'(want.minutes), 64'(minutes_o));
        report_field("seconds_whole", 64'(want.seconds), 64'(seconds_whole_o));
        report_field("seconds_frac", 64'(want.subsec), 64'(seconds_frac_o));
        report_field("range_error", 64'(want.range_error), 64'(range_error_o));
      end
    end
  end

  // Abort when neither side has moved a request for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    jd_days_i   <= '0;
    jd_frac_i   <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_dates();
    test_random_dates(800);
    test_streaming(200);
    test_backpressure(200);

    in_valid_i <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (error_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> julian_day_to_gregorian_datetime_top.f
rtl/core/jdg_pkg.sv
rtl/core/jdg_front.sv
rtl/core/jdg_fifo.sv
rtl/core/jdg_back.sv
rtl/core/julian_day_to_gregorian_datetime_top.sv
test/tb_julian_day_to_gregorian_datetime_top.sv
